// ===== hw/rtl/agb_pkg.sv =====
// ----------------------------------------------------------------------------
// agb_pkg
// Shared types and constants of the antialiased glyph blitter.
// ----------------------------------------------------------------------------
package agb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 96;
  localparam int PANEL_WIDTH_DEF   = 128;

  // Signed screen coordinate widths; they follow from the origin register
  // widths plus the largest glyph offset.
  localparam int COL_W = 11;
  localparam int ROW_W = 10;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INK_COLOR        = 3'd0,
    REG_ORIGIN_X         = 3'd1,
    REG_ORIGIN_Y         = 3'd2,
    REG_GLYPH_WIDTH      = 3'd3,
    REG_GLYPH_HEIGHT     = 3'd4,
    REG_FILL_BACKGROUND  = 3'd5,
    REG_BACKGROUND_VALUE = 3'd6
  } reg_index_t;

  localparam logic [15:0] INK_COLOR_RESET    = 16'hFFFF;
  localparam logic [6:0]  GLYPH_WIDTH_RESET  = 7'd10;
  localparam logic [6:0]  GLYPH_HEIGHT_RESET = 7'd13;

  typedef struct packed {
    logic [15:0] ink_color;
    logic [9:0]  origin_x;
    logic [8:0]  origin_y;
    logic [6:0]  glyph_width;
    logic [6:0]  glyph_height;
    logic        fill_background;
    logic [7:0]  background_value;
  } cfg_t;

  // One pixel write, already placed on a panel.
  typedef struct packed {
    logic       valid;
    logic       sel;
    logic [6:0] column;
    logic [6:0] row;
    logic       ink;
    logic [3:0] level;
  } pix_t;

  typedef struct packed {
    pix_t left;
    pix_t right;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hw/rtl/agb_front.sv =====
// ----------------------------------------------------------------------------
// agb_front
// Accepts coverage bytes, tracks the glyph position and classifies both
// pixels of a byte into panel writes.
// ----------------------------------------------------------------------------
module agb_front
  import agb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int PANEL_WIDTH   = PANEL_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    coverage_pair,
  input  queue_status_t queue_status,
  output logic          push,
  output pair_t         push_data
);

  logic [4:0] pair_column;
  logic [5:0] glyph_row;

  logic [6:0] width_clamped;
  logic [6:0] height_clamped;
  logic [5:0] bytes_per_row;
  logic       column_end;
  logic       row_end;
  logic       accept;

  logic signed [COL_W-1:0] col0;
  logic signed [COL_W-1:0] col1;
  logic signed [ROW_W-1:0] row;

  function automatic pix_t classify(logic signed [COL_W-1:0] col,
                                    logic signed [ROW_W-1:0] r,
                                    logic [3:0] level,
                                    logic fill);
    pix_t p;
    logic on_screen;
    logic signed [COL_W-1:0] shifted;
    on_screen = (col >= 0) && (r >= 0) &&
                (col < $signed(COL_W'(SCREEN_WIDTH))) &&
                (r < $signed(ROW_W'(SCREEN_HEIGHT)));
    shifted   = col - $signed(COL_W'(PANEL_WIDTH));
    p.valid   = on_screen && ((level != 4'd0) || fill);
    if (col < $signed(COL_W'(PANEL_WIDTH))) begin
      p.sel    = 1'b1;
      p.column = col[6:0];
    end else begin
      p.sel    = 1'b0;
      p.column = shifted[6:0];
    end
    p.row   = r[6:0];
    p.ink   = (level != 4'd0);
    p.level = level;
    return p;
  endfunction

  always_comb begin
    if (cfg.glyph_width == 7'd0) begin
      width_clamped = 7'd1;
    end else if (cfg.glyph_width > 7'd64) begin
      width_clamped = 7'd64;
    end else begin
      width_clamped = cfg.glyph_width;
    end
    if (cfg.glyph_height == 7'd0) begin
      height_clamped = 7'd1;
    end else if (cfg.glyph_height > 7'd64) begin
      height_clamped = 7'd64;
    end else begin
      height_clamped = cfg.glyph_height;
    end
  end

  assign bytes_per_row = 6'((width_clamped + 7'd1) >> 1);
  assign column_end    = ({1'b0, pair_column} + 6'd1) >= bytes_per_row;
  assign row_end       = ({1'b0, glyph_row} + 7'd1) >= height_clamped;

  assign col0 = $signed({cfg.origin_x[9], cfg.origin_x}) +
                $signed({5'b00000, pair_column, 1'b0});
  assign col1 = col0 + $signed(COL_W'(1));
  assign row  = $signed({cfg.origin_y[8], cfg.origin_y}) +
                $signed({4'b0000, glyph_row});

  assign push_data.left  = classify(col0, row, coverage_pair[7:4], cfg.fill_background);
  assign push_data.right = classify(col1, row, coverage_pair[3:0], cfg.fill_background);

  assign in_stall = queue_status.full;
  assign accept   = in_valid && !in_stall;
  // A byte whose pixels are all dropped never enters the queue.
  assign push     = accept && (push_data.left.valid || push_data.right.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= 5'd0;
      glyph_row   <= 6'd0;
    end else if (accept) begin
      if (column_end) begin
        pair_column <= 5'd0;
        glyph_row   <= row_end ? 6'd0 : glyph_row + 6'd1;
      end else begin
        pair_column <= pair_column + 5'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/agb_queue.sv =====
// ----------------------------------------------------------------------------
// agb_queue
// Short FIFO of classified pixel pairs between the front and back parts.
// ----------------------------------------------------------------------------
module agb_queue
  import agb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pair_t         push_data,
  input  logic          pop,
  output pair_t         head,
  output queue_status_t status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pair_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/agb_back.sv =====
// ----------------------------------------------------------------------------
// agb_back
// Takes pixel pairs from the queue, shades each pixel and presents one
// pixel write per cycle, while out_stall is low, through an output register.
// ----------------------------------------------------------------------------
module agb_back
  import agb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  queue_status_t queue_status,
  input  pair_t         head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          panel_select,
  output logic [6:0]    panel_column,
  output logic [6:0]    panel_row,
  output logic [15:0]   pixel_color,
  output logic          last_of_run
);

  logic  phase;
  logic  load;
  logic  cur_last;
  pix_t  cur;
  logic [15:0] color;

  // Each channel is scaled by (level + 16) / 32 with truncation.
  function automatic logic [15:0] scale_ink(logic [15:0] ink, logic [3:0] level);
    logic [9:0]  red;
    logic [10:0] green;
    logic [9:0]  blue;
    red   = 10'(ink[15:11]) * 10'({1'b1, level});
    green = 11'(ink[10:5]) * 11'({1'b1, level});
    blue  = 10'(ink[4:0]) * 10'({1'b1, level});
    return {red[9:5], green[10:5], blue[9:5]};
  endfunction

  assign load     = !queue_status.empty && (!out_valid || !out_stall);
  assign cur      = (phase || !head.left.valid) ? head.right : head.left;
  assign cur_last = phase || !head.left.valid || !head.right.valid;
  assign pop      = load && cur_last;
  assign color    = cur.ink ? scale_ink(cfg.ink_color, cur.level)
                            : {8'h00, cfg.background_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !cur_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      panel_select <= cur.sel;
      panel_column <= cur.column;
      panel_row    <= cur.row;
      pixel_color  <= color;
      last_of_run  <= cur_last;
    end
  end

endmodule

// ===== hw/rtl/antialiased_glyph_blitter_core.sv =====
// ----------------------------------------------------------------------------
// antialiased_glyph_blitter_core
// Draws 4-bit antialiased glyph bytes as RGB565 writes to two screen panels.
// ----------------------------------------------------------------------------
// A coverage byte is accepted every cycle while the four-entry pair queue has
// room; its position in the glyph comes from internal column and row counters
// that wrap at the end of the configured glyph. Each byte yields zero, one or
// two pixel writes, and the output register delivers one write per cycle while
// out_stall is low, so a byte with two visible pixels holds the output for both
// of its writes and bytes with one visible pixel keep pace at one per cycle. A
// byte passes through the queue and then the output register before its first
// write. Registers are written through the configuration port, which is always
// ready, and should change only while no requests are in flight.
module antialiased_glyph_blitter_core
  import agb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int PANEL_WIDTH   = PANEL_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            coverage_pair,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  panel_select,
  output logic [6:0]            panel_column,
  output logic [6:0]            panel_row,
  output logic [15:0]           pixel_color,
  output logic                  last_of_run
);

  cfg_t          cfg;
  queue_status_t q_status;
  logic          push;
  pair_t         push_data;
  logic          pop;
  pair_t         head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ink_color        <= INK_COLOR_RESET;
      cfg.origin_x         <= '0;
      cfg.origin_y         <= '0;
      cfg.glyph_width      <= GLYPH_WIDTH_RESET;
      cfg.glyph_height     <= GLYPH_HEIGHT_RESET;
      cfg.fill_background  <= 1'b0;
      cfg.background_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INK_COLOR:        cfg.ink_color        <= cfg_data;
        REG_ORIGIN_X:         cfg.origin_x         <= cfg_data[9:0];
        REG_ORIGIN_Y:         cfg.origin_y         <= cfg_data[8:0];
        REG_GLYPH_WIDTH:      cfg.glyph_width      <= cfg_data[6:0];
        REG_GLYPH_HEIGHT:     cfg.glyph_height     <= cfg_data[6:0];
        REG_FILL_BACKGROUND:  cfg.fill_background  <= cfg_data[0];
        REG_BACKGROUND_VALUE: cfg.background_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  agb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .PANEL_WIDTH   (PANEL_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .coverage_pair (coverage_pair),
    .queue_status  (q_status),
    .push          (push),
    .push_data     (push_data)
  );

  agb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  agb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .queue_status (q_status),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .panel_select (panel_select),
    .panel_column (panel_column),
    .panel_row    (panel_row),
    .pixel_color  (pixel_color),
    .last_of_run  (last_of_run)
  );

`ifndef SYNTH
  // The second pixel of a pair is always ready right behind the first.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("second pixel of a pair did not follow");

  // Queued work reaches the output as soon as the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    !q_status.empty && (!out_valid || !out_stall) |=> out_valid)
    else $error("queued request not delivered to output");

  // Input is held off exactly while the queue is full.
  assert property (@(posedge clk) disable iff (rst)
    in_stall == q_status.full)
    else $error("input stall does not track queue occupancy");
`endif

endmodule
